>>> hdl/thmlp_pkg.sv
// Shared types and constants for the tile header marker length parser.
package thmlp_pkg;

  localparam int POSITION_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] CODE_SOD    = 8'h93;
  localparam logic [7:0] CODE_PLT    = 8'h58;
  localparam logic [7:0] GROUP_MASK  = 8'h7F;
  localparam logic [7:0] MORE_BIT    = 8'h80;

  typedef enum logic [1:0] {
    KIND_PACKET_LENGTH = 2'd0,
    KIND_SOD_FOUND     = 2'd1,
    KIND_NO_SOD        = 2'd2
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  value;
  } result_t;

  // One queue entry holds every result that a single header byte produces.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

>>> hdl/thmlp_front.sv
// Front end: accepts header bytes, tracks marker segments and forms result entries.
module thmlp_front #(
  parameter int POSITION_BITS = thmlp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               end_of_header,
  output logic               push,
  output thmlp_pkg::entry_t  push_entry
);

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_PREFIX,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_PLT_INDEX,
    PH_PLT_BODY,
    PH_DONE
  } phase_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  phase_t                   phase, phase_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [7:0]               marker_low, marker_low_next;
  logic [15:0]              seg_len, seg_len_next;
  logic [15:0]              body_left, body_left_next;
  logic [31:0]              acc, acc_next;
  logic                     start_pending, start_pending_next;
  logic                     pending_offset, pending_offset_next;

  logic                     em_valid;
  thmlp_pkg::result_t       em_result;
  logic [POSITION_BITS-1:0] off_pos;
  logic [31:0]              off_clip;
  logic [15:0]              body_dec;
  logic [31:0]              acc_or;
  logic [15:0]              len_full;
  logic                     tail_no_sod;

  always_comb begin
    phase_next          = phase;
    position_next       = (position == POS_MAX) ? position : position + 1'b1;
    marker_low_next     = marker_low;
    seg_len_next        = seg_len;
    body_left_next      = body_left;
    acc_next            = acc;
    start_pending_next  = start_pending;
    pending_offset_next = pending_offset;
    em_valid            = 1'b0;
    em_result.kind      = thmlp_pkg::KIND_PACKET_LENGTH;
    em_result.value     = '0;

    off_pos = (position == POS_MAX || position == '0) ? position : position - 1'b1;
    if (POSITION_BITS > 32 && off_pos > POSITION_BITS'(33'h0FFFFFFFF)) begin
      off_clip = 32'hFFFFFFFF;
    end else begin
      off_clip = 32'(off_pos);
    end
    body_dec = (body_left == 16'd0) ? 16'd0 : body_left - 16'd1;
    acc_or   = acc | {24'd0, data_byte & thmlp_pkg::GROUP_MASK};
    len_full = {seg_len[15:8], data_byte};

    unique case (phase)
      PH_SCAN: begin
        if (data_byte == thmlp_pkg::MARK_PREFIX) begin
          phase_next = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        marker_low_next = data_byte;
        if (data_byte == thmlp_pkg::CODE_SOD) begin
          phase_next = PH_DONE;
          if (position >= POSITION_BITS'(3)) begin
            em_valid        = 1'b1;
            em_result.kind  = thmlp_pkg::KIND_SOD_FOUND;
            em_result.value = off_clip;
          end else begin
            start_pending_next  = 1'b1;
            pending_offset_next = off_pos[0];
          end
        end else begin
          phase_next = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        seg_len_next = {data_byte, 8'd0};
        phase_next   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len_next = len_full;
        if (marker_low == thmlp_pkg::CODE_PLT && len_full >= 16'd3) begin
          body_left_next = len_full - 16'd3;
          phase_next     = PH_PLT_INDEX;
        end else if (len_full > 16'd2) begin
          body_left_next = len_full - 16'd2;
          phase_next     = PH_SKIP;
        end else begin
          phase_next = PH_SCAN;
        end
      end
      PH_SKIP: begin
        body_left_next = body_dec;
        if (body_dec == 16'd0) begin
          phase_next = PH_SCAN;
        end
      end
      PH_PLT_INDEX: begin
        acc_next   = '0;
        phase_next = (body_left == 16'd0) ? PH_SCAN : PH_PLT_BODY;
      end
      PH_PLT_BODY: begin
        if ((data_byte & thmlp_pkg::MORE_BIT) != 8'd0) begin
          acc_next = {acc_or[24:0], 7'd0};
        end else begin
          em_valid        = 1'b1;
          em_result.kind  = thmlp_pkg::KIND_PACKET_LENGTH;
          em_result.value = acc_or;
          acc_next        = '0;
        end
        body_left_next = body_dec;
        if (body_dec == 16'd0) begin
          phase_next = PH_SCAN;
        end
      end
      PH_DONE: begin
        if (start_pending && position == POSITION_BITS'(3)) begin
          em_valid           = 1'b1;
          em_result.kind     = thmlp_pkg::KIND_SOD_FOUND;
          em_result.value    = {31'd0, pending_offset};
          start_pending_next = 1'b0;
        end
      end
      default: begin
        phase_next = PH_SCAN;
      end
    endcase

    tail_no_sod = end_of_header && (phase_next != PH_DONE || start_pending_next);

    // A final byte drops every piece of parse state back to its reset value.
    if (end_of_header) begin
      phase_next          = PH_SCAN;
      position_next       = '0;
      marker_low_next     = '0;
      seg_len_next        = '0;
      body_left_next      = '0;
      acc_next            = '0;
      start_pending_next  = 1'b0;
      pending_offset_next = 1'b0;
    end

    push_entry.two          = em_valid && tail_no_sod;
    push_entry.second.kind  = thmlp_pkg::KIND_NO_SOD;
    push_entry.second.value = '0;
    if (em_valid) begin
      push_entry.first = em_result;
    end else begin
      push_entry.first.kind  = thmlp_pkg::KIND_NO_SOD;
      push_entry.first.value = '0;
    end
    push = accept && (em_valid || tail_no_sod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      position       <= '0;
      marker_low     <= '0;
      seg_len        <= '0;
      body_left      <= '0;
      acc            <= '0;
      start_pending  <= 1'b0;
      pending_offset <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      position       <= position_next;
      marker_low     <= marker_low_next;
      seg_len        <= seg_len_next;
      body_left      <= body_left_next;
      acc            <= acc_next;
      start_pending  <= start_pending_next;
      pending_offset <= pending_offset_next;
    end
  end

endmodule

>>> hdl/thmlp_queue.sv
// Short first-in first-out queue of result entries between front and back.
module thmlp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  thmlp_pkg::entry_t  push_entry,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output thmlp_pkg::entry_t  head
);

  localparam int DEPTH = thmlp_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);

  thmlp_pkg::entry_t   slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [PTR_BITS:0]   count;
  logic                do_push, do_pop;

  assign full    = (count == (PTR_BITS+1)'(DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> hdl/thmlp_back.sv
// Back end: takes queued entries and delivers their results one request at a time.
module thmlp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  thmlp_pkg::entry_t  q_head,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  output logic [1:0]         m_tuser,
  output logic               m_tlast
);

  thmlp_pkg::entry_t  cur;
  logic               cur_valid;
  logic               sel_second;
  logic               entry_done;
  thmlp_pkg::result_t shown;

  assign shown      = sel_second ? cur.second : cur.first;
  assign m_tvalid   = cur_valid;
  assign m_tdata    = shown.value;
  assign m_tuser    = shown.kind;
  assign m_tlast    = sel_second || !cur.two;
  assign entry_done = cur_valid && m_tready && m_tlast;
  // The output register reloads when empty or when its last result is taken.
  assign q_pop      = !q_empty && (!cur_valid || entry_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      sel_second <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid  <= 1'b1;
        sel_second <= 1'b0;
      end else if (entry_done) begin
        cur_valid  <= 1'b0;
        sel_second <= 1'b0;
      end else if (cur_valid && m_tready) begin
        sel_second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

endmodule

>>> hdl/tile_header_marker_length_parser.sv
// Top level of the tile header marker length parser.
// Accepts one header byte per cycle unless the queue is full; results pass through the
// queue and the output register. Output runs at one result per cycle while m_tready is
// high; a four-entry queue lets input continue while output stalls.
// Synchronous active-high reset returns the parser to scanning with position zero.
module tile_header_marker_length_parser #(
  parameter int POSITION_BITS = thmlp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_header
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result_value
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast    // run_last
);

  logic              accept;
  logic              push;
  thmlp_pkg::entry_t push_entry;
  logic              q_full, q_empty, q_pop;
  thmlp_pkg::entry_t q_head;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  thmlp_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .end_of_header(s_tlast),
    .push         (push),
    .push_entry   (push_entry)
  );

  thmlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  thmlp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

>>> test/tile_header_marker_length_parser_test.sv
// Self-checking testbench for the tile header marker length parser.
`timescale 1ns / 100ps

module tile_header_marker_length_parser_test;

  localparam int POS_BITS = thmlp_pkg::POSITION_BITS_DEFAULT;
  localparam logic [63:0] POS_MAX = {64{1'b1}} >> (64 - POS_BITS);
  localparam int RANDOM_BYTES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [2:0] {
    SCAN_PREFIX,
    SAW_PREFIX,
    READ_LEN_HI,
    READ_LEN_LO,
    SKIP_BODY,
    PLT_INDEX,
    PLT_BODY,
    SOD_SEEN
  } scan_phase_t;

  typedef struct {
    thmlp_pkg::result_kind_t kind;
    logic [31:0]             value;
    logic                    last;
  } header_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  tile_header_marker_length_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Parser state as the header bytes are accepted.
  scan_phase_t phase;
  logic [63:0] byte_pos;
  logic [7:0]  marker_code;
  logic [15:0] seg_len;
  logic [15:0] body_left;
  logic [31:0] length_acc;
  logic        sod_pending;
  logic        pending_off;

  header_result_t step_res[2];
  int             step_count;
  header_result_t expected_results[$];
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int             stall_left = 0;
  bit             tx_quiet = 1'b0;
  bit             rx_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_parser_state();
    phase = SCAN_PREFIX;
    byte_pos = '0;
    marker_code = '0;
    seg_len = '0;
    body_left = '0;
    length_acc = '0;
    sod_pending = 1'b0;
    pending_off = 1'b0;
  endfunction

  function automatic void note_result(input thmlp_pkg::result_kind_t kind,
                                      input logic [63:0] value);
    if (step_count < 2) begin
      step_res[step_count].kind = kind;
      step_res[step_count].value = (value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : value[31:0];
      step_res[step_count].last = 1'b0;
      step_count++;
    end
  endfunction

  function automatic void parse_header_byte(input logic [7:0] b, input logic eoh);
    logic [63:0] pos;
    logic [63:0] off;
    pos = byte_pos;
    step_count = 0;
    if (byte_pos < POS_MAX) byte_pos = byte_pos + 1;
    case (phase)
      SCAN_PREFIX: begin
        if (b == thmlp_pkg::MARK_PREFIX) phase = SAW_PREFIX;
      end
      SAW_PREFIX: begin
        marker_code = b;
        if (b == thmlp_pkg::CODE_SOD) begin
          off = (pos == POS_MAX || pos == 0) ? pos : pos - 1;
          phase = SOD_SEEN;
          // Too early to know the header is long enough, so hold it back.
          if (pos >= 3) begin
            note_result(thmlp_pkg::KIND_SOD_FOUND, off);
          end else begin
            sod_pending = 1'b1;
            pending_off = off[0];
          end
        end else begin
          phase = READ_LEN_HI;
        end
      end
      READ_LEN_HI: begin
        seg_len = {b, 8'h00};
        phase = READ_LEN_LO;
      end
      READ_LEN_LO: begin
        seg_len = {seg_len[15:8], b};
        if (marker_code == thmlp_pkg::CODE_PLT && seg_len >= 3) begin
          body_left = seg_len - 16'd3;
          phase = PLT_INDEX;
        end else if (seg_len > 2) begin
          body_left = seg_len - 16'd2;
          phase = SKIP_BODY;
        end else begin
          phase = SCAN_PREFIX;
        end
      end
      SKIP_BODY: begin
        if (body_left > 0) body_left = body_left - 1;
        if (body_left == 0) phase = SCAN_PREFIX;
      end
      PLT_INDEX: begin
        length_acc = '0;
        phase = (body_left == 0) ? SCAN_PREFIX : PLT_BODY;
      end
      PLT_BODY: begin
        length_acc = length_acc | {24'h0, b & thmlp_pkg::GROUP_MASK};
        if ((b & thmlp_pkg::MORE_BIT) != 0) begin
          length_acc = length_acc << 7;
        end else begin
          note_result(thmlp_pkg::KIND_PACKET_LENGTH, {32'h0, length_acc});
          length_acc = '0;
        end
        if (body_left > 0) body_left = body_left - 1;
        if (body_left == 0) phase = SCAN_PREFIX;
      end
      default: begin
        if (sod_pending && pos == 3) begin
          note_result(thmlp_pkg::KIND_SOD_FOUND, {63'h0, pending_off});
          sod_pending = 1'b0;
        end
      end
    endcase
    if (eoh) begin
      if (phase != SOD_SEEN || sod_pending) note_result(thmlp_pkg::KIND_NO_SOD, 64'h0);
      clear_parser_state();
    end
    for (int i = 0; i < step_count; i++) begin
      step_res[i].last = (i == step_count - 1);
      expected_results.insert(expected_results.size(), step_res[i]);
    end
  endfunction

  function automatic void check_result();
    header_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: kind %0d value %h last %b", m_tuser, m_tdata, m_tlast);
      return;
    end
    want = expected_results.pop_front();
    if (m_tuser != want.kind || m_tdata != want.value || m_tlast != want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result mismatch: expected kind %0d value %h last %b, %s%0d value %h last %b",
                 want.kind, want.value, want.last, "got kind ", m_tuser, m_tdata, m_tlast);
    end
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0: return thmlp_pkg::MARK_PREFIX;
      1: return thmlp_pkg::CODE_SOD;
      2: return thmlp_pkg::CODE_PLT;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) parse_header_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result();
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      stall_left <= pick_gap(rx_quiet);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid stays high from one request to the next unless a gap is wanted.
  task automatic send_byte(input logic [7:0] b, input logic eoh);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eoh;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_header(input logic [7:0] hdr[$]);
    for (int i = 0; i < hdr.size(); i++) send_byte(hdr[i], i == hdr.size() - 1);
  endtask

  task automatic test_short_headers();
    logic [7:0] hdr[$];
    hdr = '{thmlp_pkg::CODE_SOD};
    send_header(hdr);
    hdr = '{thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_SOD};
    send_header(hdr);
    // Start of data at offset 1 is only reported once the fourth byte arrives.
    hdr = '{8'h00, thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_SOD, 8'h5A};
    send_header(hdr);
  endtask

  task automatic test_start_of_data();
    logic [7:0] hdr[$];
    // Doubled prefix, an empty segment, then start of data and ignored bytes.
    hdr = '{thmlp_pkg::MARK_PREFIX, thmlp_pkg::MARK_PREFIX, 8'h00, 8'h02,
            thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_SOD,
            thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_PLT};
    send_header(hdr);
  endtask

  task automatic test_packet_lengths();
    logic [7:0] hdr[$];
    // A zero length, then a wrapping length that ends with the header.
    hdr = '{thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_PLT, 8'h00, 8'h0A, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_header(hdr);
    hdr = '{thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_PLT, 8'h00, 8'h08, 8'h3C, 8'h8F,
            8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_header(hdr);
  endtask

  task automatic test_skipped_segments();
    logic [7:0] hdr[$];
    // Short packet-length segment, index-only segment, a body hiding a start of
    // data, and a header cut off inside a length field.
    hdr = '{thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_PLT, 8'h00, 8'h02,
            thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_PLT, 8'h00, 8'h03, 8'h07,
            thmlp_pkg::MARK_PREFIX, 8'h51, 8'h00, 8'h05,
            thmlp_pkg::MARK_PREFIX, thmlp_pkg::CODE_SOD, thmlp_pkg::MARK_PREFIX,
            thmlp_pkg::MARK_PREFIX, 8'h90, 8'h00};
    send_header(hdr);
  endtask

  task automatic test_random_headers();
    logic [7:0]  hdr[$];
    logic [7:0]  body[$];
    logic [63:0] v;
    logic [7:0]  code;
    logic [15:0] len_field;
    int          groups;
    int          sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      hdr.delete();
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 12)) hdr.insert(hdr.size(), noise_byte());
      end else begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) hdr.insert(hdr.size(), 8'($urandom_range(0, 254)));
        repeat ($urandom_range(0, 3)) begin
          body.delete();
          if ($urandom_range(0, 1) == 1) begin
            code = thmlp_pkg::CODE_PLT;
            body.insert(body.size(), 8'($urandom));
            repeat ($urandom_range(0, 4)) begin
              groups = $urandom_range(1, 5);
              v = {$urandom, $urandom};
              if ($urandom_range(0, 7) == 0) v = '1;
              for (int g = groups - 1; g >= 0; g--)
                body.insert(body.size(), {g != 0, v[7 * g +: 7]});
            end
            // Now and then a length left unfinished at the segment end.
            if ($urandom_range(0, 9) == 0)
              body.insert(body.size(), thmlp_pkg::MORE_BIT | 8'($urandom));
            len_field = 16'(body.size() + 2);
          end else begin
            do code = 8'($urandom); while (code == thmlp_pkg::CODE_SOD);
            repeat ($urandom_range(0, 6)) body.insert(body.size(), noise_byte());
            len_field = 16'(body.size() + 2);
            if ($urandom_range(0, 4) == 0) begin
              len_field = 16'($urandom_range(0, 2));
              body.delete();
            end
          end
          hdr.insert(hdr.size(), thmlp_pkg::MARK_PREFIX);
          hdr.insert(hdr.size(), code);
          hdr.insert(hdr.size(), len_field[15:8]);
          hdr.insert(hdr.size(), len_field[7:0]);
          foreach (body[i]) hdr.insert(hdr.size(), body[i]);
        end
        if ($urandom_range(0, 3) != 0) begin
          hdr.insert(hdr.size(), thmlp_pkg::MARK_PREFIX);
          hdr.insert(hdr.size(), thmlp_pkg::CODE_SOD);
          repeat ($urandom_range(0, 3)) hdr.insert(hdr.size(), noise_byte());
        end
        if (hdr.size() > 1 && $urandom_range(0, 7) == 0)
          hdr = hdr[0:$urandom_range(0, hdr.size() - 1)];
      end
      if (hdr.size() == 0) hdr.insert(hdr.size(), noise_byte());
      send_header(hdr);
      sent += hdr.size();
    end
  endtask

  initial begin
    clear_parser_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_short_headers();
    test_start_of_data();
    test_packet_lengths();
    test_skipped_segments();
    test_random_headers();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
